// ===== rtl/imu_frame_parser_core_macros.svh =====
// Assertion macros shared by the frame parser RTL.
// No dependencies; files that check their own logic include this header.
`ifndef IMU_FRAME_PARSER_CORE_MACROS_SVH
`define IMU_FRAME_PARSER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// checked only out of reset
`define IFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define IFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define IFP_ASSERT(label, prop, msg)
`define IFP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/imu_fp_pkg.sv =====
// Shared types, byte codes and capture layout of the IMU frame parser.
// No dependencies; used by every module of the parser.
package imu_fp_pkg;

    localparam logic [7:0] FRAME_LIMIT = 8'd198;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] SYNC_0   = 8'h41;
    localparam logic [7:0] SYNC_1   = 8'h78;
    localparam logic [7:0] SYNC_2   = 8'hFF;
    localparam logic [7:0] TAIL     = 8'h6D;

    localparam logic [7:0] CLS_SYS  = 8'h01;
    localparam logic [7:0] CLS_TEST = 8'h02;
    localparam logic [7:0] CLS_AUX  = 8'h03;
    localparam logic [7:0] CLS_DATA = 8'h06;

    localparam logic [7:0] MSG_CMD      = 8'h01;
    localparam logic [7:0] MSG_DATA     = 8'h81;
    localparam logic [7:0] MSG_CFG_ACK  = 8'h82;
    localparam logic [7:0] MSG_SELFTEST = 8'h86;

    localparam logic [15:0] ACCEL_ID_RST = 16'h8801;
    localparam logic [15:0] GYRO_ID_RST  = 16'h8C00;
    localparam logic [15:0] EULER_ID_RST = 16'hB001;

    localparam logic [1:0] CFG_ACCEL_ID = 2'd0;
    localparam logic [1:0] CFG_GYRO_ID  = 2'd1;
    localparam logic [1:0] CFG_EULER_ID = 2'd2;

    localparam logic [1:0] KIND_ACCEL  = 2'd0;
    localparam logic [1:0] KIND_GYRO   = 2'd1;
    localparam logic [1:0] KIND_EULER  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [2:0] DEV_INIT     = 3'd2;
    localparam logic [2:0] DEV_CFG_ACK  = 3'd3;
    localparam logic [2:0] DEV_SELFTEST = 3'd4;

    // captured frame bytes: three blocks of 15 bytes (2 id, 1 skipped, 3 words)
    localparam int unsigned NUM_BLOCKS  = 3;
    localparam int unsigned NUM_AXES    = 3;
    localparam int unsigned BLOCK_BYTES = 15;
    localparam int unsigned CAP_BYTES   = NUM_BLOCKS * BLOCK_BYTES;
    localparam int unsigned WORD_OFS    = 3;
    localparam int unsigned WORD_BYTES  = 4;
    // frame position 7 (self-test flags) is byte 1 of the accel block
    localparam int unsigned VALID_CAP   = 1;

    typedef logic [CAP_BYTES-1:0][7:0] t_cap;

    typedef struct packed {
        logic [3:0]                                item_mask; // accel, gyro, euler, status
        logic [2:0]                                dev_state;
        logic [3:0]                                ang_valid;
        logic [NUM_BLOCKS*NUM_AXES-1:0][31:0]      words;
    } t_job;

    // frame byte position held by capture byte i
    function automatic logic [7:0] cap_pos(input int unsigned i);
        logic [7:0] pos;
        if (i < BLOCK_BYTES) begin
            pos = 8'(6 + i);
        end else if (i < 2 * BLOCK_BYTES) begin
            pos = 8'(21 + i - BLOCK_BYTES);
        end else begin
            pos = 8'(70 + i - 2 * BLOCK_BYTES);
        end
        return pos;
    endfunction

endpackage

// ===== rtl/imu_fp_front.sv =====
// Front end: byte parser, block capture and good-frame dispatch into jobs.
// Depends on imu_fp_pkg.
module imu_fp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_job_wr,
    output imu_fp_pkg::t_job  o_job
);

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_SYNC1 = 4'd1;
    localparam logic [3:0] PH_SYNC2 = 4'd2;
    localparam logic [3:0] PH_CLASS = 4'd3;
    localparam logic [3:0] PH_MSG   = 4'd4;
    localparam logic [3:0] PH_LEN   = 4'd5;
    localparam logic [3:0] PH_PAY   = 4'd6;
    localparam logic [3:0] PH_CHECK = 4'd7;
    localparam logic [3:0] PH_TAIL  = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_idx, n_idx;
    logic [7:0]  r_check, n_check;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_msg, n_msg;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [2:0]  r_status, n_status;
    logic [3:0]  r_vflags, n_vflags;
    logic [NUM_IDS-1:0][15:0] r_id;
    imu_fp_pkg::t_cap r_cap, n_cap;

    localparam int unsigned NUM_IDS = imu_fp_pkg::NUM_BLOCKS;

    logic [3:0]  ph_eff;
    logic [7:0]  idx_eff;
    logic [7:0]  cnt_inc;
    logic        store;
    logic        dispatch;
    logic [3:0]  mask;

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_check  = r_check;
        n_class  = r_class;
        n_msg    = r_msg;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_cap    = r_cap;
        store    = 1'b0;
        dispatch = 1'b0;
        cnt_inc  = r_cnt + 8'd1;
        ph_eff   = r_phase;
        idx_eff  = r_idx;
        // frame ran into the byte limit: drop it and hunt with this byte
        if (r_idx >= imu_fp_pkg::FRAME_LIMIT) begin
            ph_eff  = PH_HUNT;
            idx_eff = '0;
        end
        if (i_valid) begin
            n_phase = ph_eff;
            n_idx   = idx_eff;
            case (ph_eff)
                PH_HUNT: begin
                    if (i_byte == imu_fp_pkg::SYNC_0) begin
                        n_cap   = '0;
                        n_check = i_byte;
                        n_class = '0;
                        n_msg   = '0;
                        n_len   = '0;
                        n_cnt   = '0;
                        store   = 1'b1;
                        n_idx   = 8'd1;
                        n_phase = PH_SYNC1;
                    end
                end
                PH_SYNC1: begin
                    if (i_byte == imu_fp_pkg::SYNC_1) begin
                        store   = 1'b1;
                        n_check = r_check ^ i_byte;
                        n_idx   = idx_eff + 8'd1;
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (i_byte == imu_fp_pkg::SYNC_2) begin
                        store   = 1'b1;
                        n_check = r_check ^ i_byte;
                        n_idx   = idx_eff + 8'd1;
                        n_phase = PH_CLASS;
                    end
                end
                PH_CLASS: begin
                    if (i_byte inside {imu_fp_pkg::CLS_SYS, imu_fp_pkg::CLS_TEST,
                                       imu_fp_pkg::CLS_AUX, imu_fp_pkg::CLS_DATA}) begin
                        n_class = i_byte;
                        store   = 1'b1;
                        n_check = r_check ^ i_byte;
                        n_idx   = idx_eff + 8'd1;
                        n_phase = PH_MSG;
                    end else begin
                        n_phase = PH_HUNT;
                        n_idx   = '0;
                    end
                end
                PH_MSG: begin
                    if (i_byte inside {imu_fp_pkg::MSG_CMD, imu_fp_pkg::MSG_DATA,
                                       imu_fp_pkg::MSG_CFG_ACK,
                                       imu_fp_pkg::MSG_SELFTEST}) begin
                        n_msg   = i_byte;
                        store   = 1'b1;
                        n_check = r_check ^ i_byte;
                        n_idx   = idx_eff + 8'd1;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_HUNT;
                        n_idx   = '0;
                    end
                end
                PH_LEN: begin
                    n_len   = i_byte;
                    store   = 1'b1;
                    n_check = r_check ^ i_byte;
                    n_idx   = idx_eff + 8'd1;
                    n_phase = (i_byte != 8'd0) ? PH_PAY : PH_CHECK;
                end
                PH_PAY: begin
                    store   = 1'b1;
                    n_check = r_check ^ i_byte;
                    n_idx   = idx_eff + 8'd1;
                    if (cnt_inc >= r_len) begin
                        n_phase = PH_CHECK;
                        n_cnt   = '0;
                    end else begin
                        n_cnt   = cnt_inc;
                    end
                end
                PH_CHECK: begin
                    // check byte lands in the store even when it fails
                    store = 1'b1;
                    if (r_check == i_byte) begin
                        n_idx   = idx_eff + 8'd1;
                        n_phase = PH_TAIL;
                    end else begin
                        n_phase = PH_HUNT;
                        n_idx   = '0;
                    end
                end
                PH_TAIL: begin
                    store = 1'b1;
                    if (i_byte == imu_fp_pkg::TAIL) begin
                        dispatch = 1'b1;
                        n_check  = '0;
                        n_len    = '0;
                        n_msg    = '0;
                        n_class  = '0;
                        n_cnt    = '0;
                    end
                    n_phase = PH_HUNT;
                    n_idx   = '0;
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_idx   = '0;
                end
            endcase
            if (store) begin
                for (int i = 0; i < imu_fp_pkg::CAP_BYTES; i++) begin
                    if (idx_eff == imu_fp_pkg::cap_pos(i)) begin
                        n_cap[i] = i_byte;
                    end
                end
            end
        end
    end

    // dispatch works on the store as it stands after the tail byte
    always_comb begin
        n_status = r_status;
        n_vflags = r_vflags;
        mask     = '0;
        if (dispatch) begin
            if (r_class == imu_fp_pkg::CLS_SYS && r_msg == imu_fp_pkg::MSG_CFG_ACK) begin
                n_status = imu_fp_pkg::DEV_CFG_ACK;
                mask     = 4'b1000;
            end else if (r_class == imu_fp_pkg::CLS_TEST &&
                         r_msg == imu_fp_pkg::MSG_SELFTEST) begin
                n_status = imu_fp_pkg::DEV_SELFTEST;
                n_vflags = n_cap[imu_fp_pkg::VALID_CAP][7:4];
                mask     = 4'b1000;
            end else if (r_class == imu_fp_pkg::CLS_DATA &&
                         r_msg == imu_fp_pkg::MSG_DATA) begin
                for (int k = 0; k < NUM_IDS; k++) begin
                    mask[k] = ({n_cap[k*imu_fp_pkg::BLOCK_BYTES + 1],
                                n_cap[k*imu_fp_pkg::BLOCK_BYTES]} == r_id[k]);
                end
            end
        end
    end

    always_comb begin
        o_job_wr        = (mask != 4'd0);
        o_job.item_mask = mask;
        o_job.dev_state = n_status;
        o_job.ang_valid = n_vflags;
        for (int k = 0; k < imu_fp_pkg::NUM_BLOCKS; k++) begin
            for (int j = 0; j < imu_fp_pkg::NUM_AXES; j++) begin
                o_job.words[k*imu_fp_pkg::NUM_AXES + j] = {
                    n_cap[k*imu_fp_pkg::BLOCK_BYTES + imu_fp_pkg::WORD_OFS
                          + j*imu_fp_pkg::WORD_BYTES + 3],
                    n_cap[k*imu_fp_pkg::BLOCK_BYTES + imu_fp_pkg::WORD_OFS
                          + j*imu_fp_pkg::WORD_BYTES + 2],
                    n_cap[k*imu_fp_pkg::BLOCK_BYTES + imu_fp_pkg::WORD_OFS
                          + j*imu_fp_pkg::WORD_BYTES + 1],
                    n_cap[k*imu_fp_pkg::BLOCK_BYTES + imu_fp_pkg::WORD_OFS
                          + j*imu_fp_pkg::WORD_BYTES]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_idx    <= '0;
            r_check  <= '0;
            r_class  <= '0;
            r_msg    <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_status <= imu_fp_pkg::DEV_INIT;
            r_vflags <= '0;
            r_id[0]  <= imu_fp_pkg::ACCEL_ID_RST;
            r_id[1]  <= imu_fp_pkg::GYRO_ID_RST;
            r_id[2]  <= imu_fp_pkg::EULER_ID_RST;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_check  <= n_check;
            r_class  <= n_class;
            r_msg    <= n_msg;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_status <= n_status;
            r_vflags <= n_vflags;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    imu_fp_pkg::CFG_ACCEL_ID: r_id[0] <= i_cfg_data;
                    imu_fp_pkg::CFG_GYRO_ID:  r_id[1] <= i_cfg_data;
                    imu_fp_pkg::CFG_EULER_ID: r_id[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // capture bytes are cleared at every header, so no reset needed
    always_ff @(posedge i_clk) begin
        r_cap <= n_cap;
    end

endmodule

// ===== rtl/imu_fp_fifo.sv =====
// Short job queue between parser front end and item back end.
// Depends on imu_fp_pkg and the assertion macro header.
`include "imu_frame_parser_core_macros.svh"
module imu_fp_fifo #(
    parameter int unsigned DEPTH = imu_fp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  imu_fp_pkg::t_job  i_data,
    output logic              o_full,
    input  logic              i_rd,
    output imu_fp_pkg::t_job  o_data,
    output logic              o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    imu_fp_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `IFP_ASSERT(a_no_write_when_full, !(i_wr && o_full), "job written into full queue")
    `IFP_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(DEPTH), "queue count overflow")

endmodule

// ===== rtl/imu_fp_back.sv =====
// Back end: expands one job into its result items, one item per pop.
// Depends on imu_fp_pkg and the assertion macro header.
`include "imu_frame_parser_core_macros.svh"
module imu_fp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_avail,
    input  imu_fp_pkg::t_job  i_job,
    output logic              o_job_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [1:0]        o_item_kind,
    output logic [31:0]       o_word_x,
    output logic [31:0]       o_word_y,
    output logic [31:0]       o_word_z,
    output logic [2:0]        o_device_state,
    output logic [3:0]        o_angle_valid,
    output logic              o_last
);

    logic [3:0]        r_mask, n_mask;
    imu_fp_pkg::t_job  r_job;
    logic [1:0]        kind;
    logic [3:0]        cur_bit;
    logic              take;

    // oldest pending item is the lowest set bit of the remaining mask
    always_comb begin
        kind = imu_fp_pkg::KIND_STATUS;
        if (r_mask[0]) begin
            kind = imu_fp_pkg::KIND_ACCEL;
        end else if (r_mask[1]) begin
            kind = imu_fp_pkg::KIND_GYRO;
        end else if (r_mask[2]) begin
            kind = imu_fp_pkg::KIND_EULER;
        end
    end

    assign cur_bit  = 4'b0001 << kind;
    assign o_last   = ((r_mask & ~cur_bit) == 4'd0);
    assign o_empty  = (r_mask == 4'd0);
    assign take     = i_pop && !o_empty;
    assign o_job_rd = i_job_avail && (o_empty || (take && o_last));

    always_comb begin
        n_mask = r_mask;
        if (o_job_rd) begin
            n_mask = i_job.item_mask;
        end else if (take) begin
            n_mask = r_mask & ~cur_bit;
        end
    end

    always_comb begin
        o_word_x = '0;
        o_word_y = '0;
        o_word_z = '0;
        case (kind)
            imu_fp_pkg::KIND_ACCEL: begin
                o_word_x = r_job.words[0];
                o_word_y = r_job.words[1];
                o_word_z = r_job.words[2];
            end
            imu_fp_pkg::KIND_GYRO: begin
                o_word_x = r_job.words[3];
                o_word_y = r_job.words[4];
                o_word_z = r_job.words[5];
            end
            imu_fp_pkg::KIND_EULER: begin
                o_word_x = r_job.words[6];
                o_word_y = r_job.words[7];
                o_word_z = r_job.words[8];
            end
            default: ;
        endcase
    end

    assign o_item_kind    = kind;
    assign o_device_state = r_job.dev_state;
    assign o_angle_valid  = r_job.ang_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_rd) begin
            r_job <= i_job;
        end
    end

    `IFP_ASSERT(a_more_items_stay, (take && !o_last) |=> !o_empty, "items of a job lost")
    `IFP_ASSERT(a_drain_to_empty, (take && o_last && !i_job_avail) |=> o_empty,
        "item repeated after last of job")
    `IFP_ASSERT_ALWAYS(a_status_alone, r_mask[3] |-> (r_mask[2:0] == 3'd0),
        "status item mixed with block items")

endmodule

// ===== rtl/imu_frame_parser_core.sv =====
// Frame parser top: one received byte per cycle while full is low.
// A good frame's job goes through the job queue into the output stage before its first
// result shows; results then leave one per cycle while pop is high. full rises only
// when the job queue holds QUEUE_DEPTH frames and the output stage is still busy.
// Synchronous active-low reset: parser hunts for a header, block ids take their
// default values, device status is 2, no results are pending.
module imu_frame_parser_core #(
    parameter int unsigned QUEUE_DEPTH = imu_fp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_item_kind,
    output logic [31:0] o_word_x,
    output logic [31:0] o_word_y,
    output logic [31:0] o_word_z,
    output logic [2:0]  o_device_state,
    output logic [3:0]  o_angle_valid,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic              accept;
    logic              job_wr;
    imu_fp_pkg::t_job  job_in;
    imu_fp_pkg::t_job  job_out;
    logic              job_empty;
    logic              job_rd;

    assign accept = push && !full;

    imu_fp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_byte      (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_wr    (job_wr),
        .o_job       (job_in)
    );

    imu_fp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_data  (job_in),
        .o_full  (full),
        .i_rd    (job_rd),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    imu_fp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_avail    (!job_empty),
        .i_job          (job_out),
        .o_job_rd       (job_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_item_kind    (o_item_kind),
        .o_word_x       (o_word_x),
        .o_word_y       (o_word_y),
        .o_word_z       (o_word_z),
        .o_device_state (o_device_state),
        .o_angle_valid  (o_angle_valid),
        .o_last         (o_last)
    );

endmodule
